// ----- design/fpsm_pkg.sv -----
// ----------------------------------------------------------------------------
// fpsm_pkg: shared types and constants of the flywheel pulse and stroke monitor
// Beat formats, register indexes, reset values and widths of the shared units.
// ----------------------------------------------------------------------------
`default_nettype none

package fpsm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int TIME_BITS   = 32;

  // Configuration register widths and port width.
  localparam int THR_W  = 12;
  localparam int HYS_W  = 11;
  localparam int CFG_W  = 24;
  localparam int IDX_W  = 3;

  // Comparator width: wide enough for a sample plus the hysteresis.
  localparam int CMP_W = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_LIGHT_THRESHOLD    = 3'd0;
  localparam logic [IDX_W-1:0] REG_LIGHT_HYSTERESIS   = 3'd1;
  localparam logic [IDX_W-1:0] REG_METRES_PER_PULSE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_CALORIES_PER_METRE = 3'd3;
  localparam logic [IDX_W-1:0] REG_STROKE_GAP_TICKS   = 3'd4;
  localparam logic [IDX_W-1:0] REG_IDLE_TIMEOUT_TICKS = 3'd5;

  // Register reset values.
  localparam logic [THR_W-1:0] RST_LIGHT_THRESHOLD    = 12'd2048;
  localparam logic [HYS_W-1:0] RST_LIGHT_HYSTERESIS   = 11'd100;
  localparam logic [23:0]      RST_METRES_PER_PULSE   = 24'd6554;
  localparam logic [23:0]      RST_CALORIES_PER_METRE = 24'd3932;
  localparam logic [15:0]      RST_STROKE_GAP_TICKS   = 16'd300;
  localparam logic [15:0]      RST_IDLE_TIMEOUT_TICKS = 16'd3000;

  // Serial divider: dividend is metres_per_pulse * 1000 (34 bits) or the rate numerator.
  localparam int DIV_W     = 34;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  // 60000 strokes per minute in Q8.
  localparam logic [DIV_W-1:0] RATE_NUM = 34'd15360000;

  // Serial multiplier: 40-bit distance by 24-bit calories per metre.
  localparam int MUL_A_W   = 40;
  localparam int MUL_B_W   = 24;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] light_sample;
    logic                   running;
    logic                   clear_session;
  } tick_t;

  typedef struct packed {
    logic [39:0] distance_q16;
    logic [39:0] calories_q16;
    logic [23:0] speed_q16;
    logic [23:0] stroke_rate_q8;
    logic [23:0] stroke_total;
    logic [31:0] pulse_total;
    logic        pulse_now;
    logic        stroke_active;
  } report_t;

endpackage

`default_nettype wire

// ----- design/fpsm_div.sv -----
// ----------------------------------------------------------------------------
// fpsm_div: serial restoring divider
// One quotient bit a cycle; the quotient is saturated to 24 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsm_div
  import fpsm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIV_W-1:0]     dividend,
  input  wire logic [TIME_BITS-1:0] divisor,
  output logic                      done,
  output logic [23:0]               quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_BITS-1:0] divr;
  logic [TIME_BITS-1:0] rem;
  logic [DIV_W-1:0]     quo;
  logic [TIME_BITS:0]   rem_sh;
  logic                 ge;
  logic [TIME_BITS:0]   rem_sub;

  assign rem_sh  = {rem, quo[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, divr};
  assign rem_sub = rem_sh - {1'b0, divr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == DIV_CNT_W'(DIV_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divr <= divisor;
      rem  <= '0;
      quo  <= dividend;
    end else if (busy) begin
      rem <= ge ? rem_sub[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  // Saturate anything above 24 bits.
  assign quotient = (|quo[DIV_W-1:24]) ? 24'hFFFFFF : quo[23:0];

endmodule

`default_nettype wire

// ----- design/fpsm_mul.sv -----
// ----------------------------------------------------------------------------
// fpsm_mul: serial shift-and-add multiplier
// Multiplier bits are taken most significant first, one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsm_mul
  import fpsm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic                    done,
  output logic [MUL_P_W-1:0]      product
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MUL_A_W-1:0]   a_reg;
  logic [MUL_B_W-1:0]   b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == MUL_CNT_W'(MUL_B_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg   <= a;
      b_sh    <= b;
      product <= '0;
    end else if (busy) begin
      product <= {product[MUL_P_W-2:0], 1'b0} +
                 (b_sh[MUL_B_W-1] ? MUL_P_W'(a_reg) : '0);
      b_sh    <= {b_sh[MUL_B_W-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// ----- design/flywheel_pulse_stroke_monitor.sv -----
// ----------------------------------------------------------------------------
// flywheel_pulse_stroke_monitor: paddle pulse, distance and stroke monitor
// Takes one beat per millisecond tick and returns one report beat for it.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                  | Beat
//  ---------+-----------+----------------------------+----------------------
//  tick     | in        | tick_valid / tick_stall    | tick_t (sample, flags)
//  report   | out       | report_valid / report_stall| report_t (totals)
//  cfg      | in        | cfg_we (no handshake back) | cfg_index, cfg_data
//
//  The comparator and counters are updated at the edge that accepts a tick.
//  After it, the serial divider (start, 34 quotient bits, done) works out
//  the speed and then the stroke rate when a pulse calls for them, the
//  serial multiplier (start, 24 product bits, done) works out calories on
//  every tick, and then the report is loaded. The next tick can be taken
//  in the cycle after the load.
//  Reset is synchronous and restores the register defaults and clears all
//  session state and the tick counter. tick_stall is high while a tick is
//  being worked on; a finished report waits in its register while report_stall
//  is high, and the next tick may be taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module flywheel_pulse_stroke_monitor
  import fpsm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             tick_valid,
  output logic                  tick_stall,
  input  wire tick_t            tick,
  output logic                  report_valid,
  input  wire logic             report_stall,
  output report_t               report,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int TB = TIME_BITS;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SPD  = 3'd1;
  localparam logic [2:0] ST_RATE = 3'd2;
  localparam logic [2:0] ST_CAL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // Configuration registers.
  logic [THR_W-1:0] light_threshold;
  logic [HYS_W-1:0] light_hysteresis;
  logic [23:0]      metres_per_pulse;
  logic [23:0]      calories_per_metre;
  logic [15:0]      stroke_gap_ticks;
  logic [15:0]      idle_timeout_ticks;

  // Session state.
  logic [TB-1:0] tick_counter;
  logic          light_blocked;
  logic [TB-1:0] pulse_time;
  logic          pulse_time_valid;
  logic [TB-1:0] pulse_interval;
  logic [31:0]   pulse_count;
  logic [39:0]   distance_acc;
  logic [23:0]   speed_reg;
  logic [23:0]   rate_reg;
  logic [23:0]   stroke_count;
  logic          in_stroke;
  logic [TB-1:0] stroke_start_time;
  logic          stroke_time_valid;

  // Per-tick working registers.
  logic [2:0]    state;
  logic          launched;
  logic          pulse_now;
  logic          do_rate;
  logic [TB-1:0] stroke_interval;
  logic [39:0]   calories;

  // Next values computed in the accept cycle.
  logic          light_blocked_next;
  logic [TB-1:0] pulse_time_next;
  logic          pulse_time_valid_next;
  logic [TB-1:0] pulse_interval_next;
  logic [31:0]   pulse_count_next;
  logic [39:0]   distance_acc_next;
  logic [23:0]   speed_reg_next;
  logic [23:0]   rate_reg_next;
  logic [23:0]   stroke_count_next;
  logic          in_stroke_next;
  logic [TB-1:0] stroke_start_time_next;
  logic          stroke_time_valid_next;
  logic          pulse_now_next;
  logic          do_speed_next;
  logic          do_rate_next;
  logic [TB-1:0] stroke_interval_next;

  logic          accept;
  logic          report_load;
  logic [TB-1:0] now;
  logic [CMP_W-1:0] sample_ext;
  logic [CMP_W-1:0] sample_plus_hys;
  logic [CMP_W-1:0] thr_ext;
  logic [CMP_W-1:0] thr_plus_hys;
  logic [40:0]   dist_sum;
  logic [TB-1:0] stroke_since;
  logic [TB-1:0] quiet;

  // Arithmetic units: the divider is shared by speed and stroke rate.
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [TB-1:0]    div_divisor;
  logic             div_done;
  logic [23:0]      div_quotient;
  logic [DIV_W-1:0] speed_num;
  logic             mul_start;
  logic             mul_done;
  logic [MUL_P_W-1:0] mul_product;

  assign accept      = tick_valid && !tick_stall;
  assign tick_stall  = (state != ST_IDLE);
  assign now         = tick_counter;
  // The report register is loaded when it is free or being emptied this cycle.
  assign report_load = (state == ST_OUT) && (!report_valid || !report_stall);

  // ---------------------------------------------------------------------------
  // Configuration writes. Indexes beyond the list are ignored.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      light_threshold    <= RST_LIGHT_THRESHOLD;
      light_hysteresis   <= RST_LIGHT_HYSTERESIS;
      metres_per_pulse   <= RST_METRES_PER_PULSE;
      calories_per_metre <= RST_CALORIES_PER_METRE;
      stroke_gap_ticks   <= RST_STROKE_GAP_TICKS;
      idle_timeout_ticks <= RST_IDLE_TIMEOUT_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIGHT_THRESHOLD:    light_threshold    <= cfg_data[THR_W-1:0];
        REG_LIGHT_HYSTERESIS:   light_hysteresis   <= cfg_data[HYS_W-1:0];
        REG_METRES_PER_PULSE:   metres_per_pulse   <= cfg_data[23:0];
        REG_CALORIES_PER_METRE: calories_per_metre <= cfg_data[23:0];
        REG_STROKE_GAP_TICKS:   stroke_gap_ticks   <= cfg_data[15:0];
        REG_IDLE_TIMEOUT_TICKS: idle_timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Accept-cycle step: session clear, comparator with hysteresis, pulse
  // bookkeeping, stroke entry and the gap and idle timeouts. The two
  // divisions are only flagged here and are carried out afterwards.
  // ---------------------------------------------------------------------------
  assign sample_ext      = CMP_W'(tick.light_sample);
  assign thr_ext         = CMP_W'(light_threshold);
  // sample < threshold - hysteresis, rewritten so that nothing goes negative.
  assign sample_plus_hys = sample_ext + CMP_W'(light_hysteresis);
  assign thr_plus_hys    = thr_ext + CMP_W'(light_hysteresis);

  always_comb begin
    // A clear empties the session before the tick is processed.
    light_blocked_next     = tick.clear_session ? 1'b0 : light_blocked;
    pulse_time_next        = tick.clear_session ? '0   : pulse_time;
    pulse_time_valid_next  = tick.clear_session ? 1'b0 : pulse_time_valid;
    pulse_interval_next    = tick.clear_session ? '0   : pulse_interval;
    pulse_count_next       = tick.clear_session ? '0   : pulse_count;
    distance_acc_next      = tick.clear_session ? '0   : distance_acc;
    speed_reg_next         = tick.clear_session ? '0   : speed_reg;
    rate_reg_next          = tick.clear_session ? '0   : rate_reg;
    stroke_count_next      = tick.clear_session ? '0   : stroke_count;
    in_stroke_next         = tick.clear_session ? 1'b0 : in_stroke;
    stroke_start_time_next = tick.clear_session ? '0   : stroke_start_time;
    stroke_time_valid_next = tick.clear_session ? 1'b0 : stroke_time_valid;

    pulse_now_next       = 1'b0;
    do_speed_next        = 1'b0;
    do_rate_next         = 1'b0;
    stroke_interval_next = stroke_interval;
    dist_sum             = {1'b0, distance_acc_next} + 41'(metres_per_pulse);
    stroke_since         = now - stroke_start_time_next;
    quiet                = '0;

    if (tick.running) begin
      if (!light_blocked_next && (sample_plus_hys < thr_ext)) begin
        light_blocked_next = 1'b1;
        pulse_now_next     = 1'b1;
      end else if (light_blocked_next && (sample_ext > thr_plus_hys)) begin
        light_blocked_next = 1'b0;
      end

      if (pulse_now_next) begin
        if (pulse_time_valid_next) begin
          pulse_interval_next = now - pulse_time_next;
        end
        pulse_time_next       = now;
        pulse_time_valid_next = 1'b1;
        pulse_count_next      = pulse_count_next + 32'd1;
        distance_acc_next     = dist_sum[40] ? 40'hFFFFFFFFFF : dist_sum[39:0];
        do_speed_next         = (pulse_interval_next != '0);

        if (!in_stroke_next) begin
          in_stroke_next         = 1'b1;
          do_rate_next           = stroke_time_valid_next && (stroke_since != '0);
          stroke_interval_next   = stroke_since;
          stroke_start_time_next = now;
          stroke_time_valid_next = 1'b1;
          stroke_count_next      = stroke_count_next + 24'd1;
        end
      end

      // After a pulse on this tick the silence is zero, so neither timeout
      // can fire on the same tick as a division.
      if (pulse_time_valid_next) begin
        quiet = now - pulse_time_next;
        if (in_stroke_next && (quiet > TB'(stroke_gap_ticks))) begin
          in_stroke_next = 1'b0;
        end
        if (quiet > TB'(idle_timeout_ticks)) begin
          speed_reg_next = '0;
          rate_reg_next  = '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer. Each arithmetic phase issues one start to its unit and
  // waits for the unit's done.
  // ---------------------------------------------------------------------------
  // metres_per_pulse * 1000 as 1024x - 16x - 8x.
  assign speed_num = (DIV_W'(metres_per_pulse) << 10) - (DIV_W'(metres_per_pulse) << 4) -
                     (DIV_W'(metres_per_pulse) << 3);

  assign div_start    = ((state == ST_SPD) || (state == ST_RATE)) && !launched;
  assign div_dividend = (state == ST_SPD) ? speed_num : RATE_NUM;
  assign div_divisor  = (state == ST_SPD) ? pulse_interval : stroke_interval;
  assign mul_start    = (state == ST_CAL) && !launched;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      launched          <= 1'b0;
      report_valid      <= 1'b0;
      tick_counter      <= '0;
      light_blocked     <= 1'b0;
      pulse_time        <= '0;
      pulse_time_valid  <= 1'b0;
      pulse_interval    <= '0;
      pulse_count       <= '0;
      distance_acc      <= '0;
      speed_reg         <= '0;
      rate_reg          <= '0;
      stroke_count      <= '0;
      in_stroke         <= 1'b0;
      stroke_start_time <= '0;
      stroke_time_valid <= 1'b0;
      do_rate           <= 1'b0;
    end else begin
      if (report_load) begin
        report_valid <= 1'b1;
      end else if (!report_stall) begin
        report_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            tick_counter      <= now + 1'b1;
            light_blocked     <= light_blocked_next;
            pulse_time        <= pulse_time_next;
            pulse_time_valid  <= pulse_time_valid_next;
            pulse_interval    <= pulse_interval_next;
            pulse_count       <= pulse_count_next;
            distance_acc      <= distance_acc_next;
            speed_reg         <= speed_reg_next;
            rate_reg          <= rate_reg_next;
            stroke_count      <= stroke_count_next;
            in_stroke         <= in_stroke_next;
            stroke_start_time <= stroke_start_time_next;
            stroke_time_valid <= stroke_time_valid_next;
            do_rate           <= do_rate_next;
            launched          <= 1'b0;
            if (do_speed_next) begin
              state <= ST_SPD;
            end else if (do_rate_next) begin
              state <= ST_RATE;
            end else begin
              state <= ST_CAL;
            end
          end
        end
        ST_SPD: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (div_done) begin
            speed_reg <= div_quotient;
            launched  <= 1'b0;
            state     <= do_rate ? ST_RATE : ST_CAL;
          end
        end
        ST_RATE: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (div_done) begin
            rate_reg <= div_quotient;
            launched <= 1'b0;
            state    <= ST_CAL;
          end
        end
        ST_CAL: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mul_done) begin
            launched <= 1'b0;
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Load the report once the register is free or being emptied.
          if (report_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state    <= ST_IDLE;
          launched <= 1'b0;
        end
      endcase
    end
  end

  // Per-tick payload registers.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && accept) begin
      pulse_now       <= pulse_now_next;
      stroke_interval <= stroke_interval_next;
    end
    if ((state == ST_CAL) && launched && mul_done) begin
      // Calories are the product shifted down by 16, saturated to 40 bits.
      calories <= (|mul_product[MUL_P_W-1:56]) ? 40'hFFFFFFFFFF : mul_product[55:16];
    end
    if (report_load) begin
      report.distance_q16   <= distance_acc;
      report.calories_q16   <= calories;
      report.speed_q16      <= speed_reg;
      report.stroke_rate_q8 <= rate_reg;
      report.stroke_total   <= stroke_count;
      report.pulse_total    <= pulse_count;
      report.pulse_now      <= pulse_now;
      report.stroke_active  <= in_stroke;
    end
  end

  fpsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  fpsm_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (distance_acc),
    .b       (calories_per_metre),
    .done    (mul_done),
    .product (mul_product)
  );

endmodule

`default_nettype wire
